// ----- design/bber_pkg.sv -----
// Shared constants and types for the bad block extent remapper.
// Used by the extent cell and by the top level; depends on nothing else.
package bber_pkg;

  localparam int MAX_EXTENTS = 32;
  localparam int MAX_BLOCKS  = 4096;

  // Widths of the item fields.
  localparam int KIND_W = 2;
  localparam int LB_W   = 12;
  localparam int PB_W   = 12;

  // Block numbers, counters and extent lengths.
  localparam int BLK_W = $clog2(MAX_BLOCKS);
  localparam int CTR_W = $clog2(MAX_BLOCKS + 1);
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CMP_W = ((CTR_W > LB_W) ? CTR_W : LB_W) + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_XLATE  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  // Table update broadcast to every cell during a scan.
  typedef struct packed {
    logic             open;
    logic             grow;
    logic [IDX_W-1:0] idx;
    logic [BLK_W-1:0] pbase;
    logic [BLK_W-1:0] lbase;
  } wr_t;

  // Translate request walking down the chain of cells.
  typedef struct packed {
    logic            valid;
    logic            done;
    logic            hit;
    logic [LB_W-1:0] lb;
    logic [PB_W-1:0] phys;
  } tok_t;

endpackage

// ----- design/bber_cell.sv -----
// One extent of the skip table together with one stage of the search chain.
// Depends on bber_pkg for the update and search token types.
module bber_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bber_pkg::IDX_W-1:0] my_idx,
  input  logic                      active,
  input  bber_pkg::wr_t             wr,
  input  bber_pkg::tok_t            tok_in,
  output bber_pkg::tok_t            tok_out
);

  logic [bber_pkg::BLK_W-1:0] pbase_r;
  logic [bber_pkg::BLK_W-1:0] lbase_r;
  logic [bber_pkg::CTR_W-1:0] len_r;
  bber_pkg::tok_t             tok_r;
  bber_pkg::tok_t             tok_nxt;

  logic [bber_pkg::CMP_W-1:0] lb_ext;
  logic [bber_pkg::CMP_W-1:0] lbase_ext;
  logic [bber_pkg::CMP_W-1:0] end_ext;
  logic [bber_pkg::CMP_W-1:0] phys_ext;

  always_ff @(posedge clk) begin
    if (wr.open && (wr.idx == my_idx)) begin
      pbase_r <= wr.pbase;
      lbase_r <= wr.lbase;
      len_r   <= bber_pkg::CTR_W'(1);
    end else if (wr.grow && (wr.idx == my_idx)) begin
      len_r <= len_r + 1'b1;
    end
  end

  assign lb_ext    = bber_pkg::CMP_W'(tok_in.lb);
  assign lbase_ext = bber_pkg::CMP_W'(lbase_r);
  assign end_ext   = lbase_ext + bber_pkg::CMP_W'(len_r);
  assign phys_ext  = bber_pkg::CMP_W'(pbase_r) + lb_ext - lbase_ext;

  // The first live extent whose end lies above the request settles it;
  // reaching a cell past the recorded extents settles it as not found.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.done) begin
      if (!active) begin
        tok_nxt.done = 1'b1;
      end else if (lb_ext < end_ext) begin
        tok_nxt.done = 1'b1;
        if (lb_ext >= lbase_ext) begin
          tok_nxt.hit  = 1'b1;
          tok_nxt.phys = phys_ext[bber_pkg::PB_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.done <= tok_nxt.done;
    tok_r.hit  <= tok_nxt.hit;
    tok_r.lb   <= tok_nxt.lb;
    tok_r.phys <= tok_nxt.phys;
  end

  assign tok_out = tok_r;

endmodule

// ----- design/bad_block_extent_remap.sv -----
// Top level of the bad block extent remapper: scan counters, the chain of
// extent cells and the result register. Depends on bber_pkg and bber_cell.
//
// A clear or status request is taken without a stall and gives no result;
// a request of the unused kind is dropped. A translate request enters the
// first of MAX_EXTENTS extent cells and moves one cell per clock; from the
// last cell its result passes through the result register into the output
// register. The input stalls until that result has moved into the output
// register, so no new request is taken while a translate is in flight, and a
// stalled output holds off the next request. The table needs no clearing
// pass: the extent count alone marks which cells hold live entries.
module bad_block_extent_remap (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bber_pkg::KIND_W-1:0] in_kind,
  input  logic                        in_block_bad,
  input  logic [bber_pkg::LB_W-1:0]   in_logical_block,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bber_pkg::PB_W-1:0]   out_physical_block,
  output logic                        out_found,
  output logic                        out_table_overflow
);

  logic                       in_acc;
  bber_pkg::kind_t            kind;

  logic [bber_pkg::CNT_W-1:0] count_r,    count_nxt;
  logic [bber_pkg::CTR_W-1:0] pcnt_r,     pcnt_nxt;
  logic [bber_pkg::CTR_W-1:0] lcnt_r,     lcnt_nxt;
  logic                       prev_bad_r, prev_bad_nxt;
  logic                       ovf_r,      ovf_nxt;
  logic                       busy_r,     busy_nxt;
  logic [bber_pkg::CNT_W-1:0] last_idx;

  bber_pkg::wr_t              wr;
  bber_pkg::tok_t             tok [bber_pkg::MAX_EXTENTS+1];
  logic [bber_pkg::MAX_EXTENTS-1:0] active;

  logic                       res_valid_r;
  logic                       res_hit_r;
  logic [bber_pkg::PB_W-1:0]  res_phys_r;
  logic                       out_valid_r;
  logic                       out_found_r;
  logic                       out_ovf_r;
  logic [bber_pkg::PB_W-1:0]  out_phys_r;
  logic                       out_load;

  assign kind     = bber_pkg::kind_t'(in_kind);
  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign last_idx = count_r - 1'b1;
  assign out_load = res_valid_r && (!out_valid_r || !out_stall);

  always_comb begin
    count_nxt    = count_r;
    pcnt_nxt     = pcnt_r;
    lcnt_nxt     = lcnt_r;
    prev_bad_nxt = prev_bad_r;
    ovf_nxt      = ovf_r;
    busy_nxt     = busy_r;
    wr.open      = 1'b0;
    wr.grow      = 1'b0;
    wr.idx       = count_r[bber_pkg::IDX_W-1:0];
    wr.pbase     = pcnt_r[bber_pkg::BLK_W-1:0];
    wr.lbase     = lcnt_r[bber_pkg::BLK_W-1:0];
    if (out_load) begin
      busy_nxt = 1'b0;
    end
    if (in_acc) begin
      case (kind)
        bber_pkg::KIND_CLEAR: begin
          count_nxt    = '0;
          pcnt_nxt     = '0;
          lcnt_nxt     = '0;
          prev_bad_nxt = 1'b1;
          ovf_nxt      = 1'b0;
        end
        bber_pkg::KIND_STATUS: begin
          if (pcnt_r < bber_pkg::CTR_W'(bber_pkg::MAX_BLOCKS)) begin
            if (in_block_bad) begin
              prev_bad_nxt = 1'b1;
            end else begin
              if (prev_bad_r &&
                  (count_r < bber_pkg::CNT_W'(bber_pkg::MAX_EXTENTS))) begin
                // A new run starts with a length of one.
                wr.open   = 1'b1;
                count_nxt = count_r + 1'b1;
              end else if (prev_bad_r) begin
                ovf_nxt = 1'b1;
              end else if (!ovf_r && (count_r != '0)) begin
                wr.grow = 1'b1;
                wr.idx  = last_idx[bber_pkg::IDX_W-1:0];
              end
              prev_bad_nxt = 1'b0;
              lcnt_nxt     = lcnt_r + 1'b1;
            end
            pcnt_nxt = pcnt_r + 1'b1;
          end
        end
        bber_pkg::KIND_XLATE: begin
          busy_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pcnt_r     <= '0;
      lcnt_r     <= '0;
      prev_bad_r <= 1'b1;
      ovf_r      <= 1'b0;
      busy_r     <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      pcnt_r     <= pcnt_nxt;
      lcnt_r     <= lcnt_nxt;
      prev_bad_r <= prev_bad_nxt;
      ovf_r      <= ovf_nxt;
      busy_r     <= busy_nxt;
    end
  end

  always_comb begin
    tok[0].valid = in_acc && (kind == bber_pkg::KIND_XLATE);
    tok[0].done  = 1'b0;
    tok[0].hit   = 1'b0;
    tok[0].lb    = in_logical_block;
    tok[0].phys  = '0;
  end

  for (genvar i = 0; i < bber_pkg::MAX_EXTENTS; i++) begin : g_cell
    assign active[i] = (bber_pkg::CNT_W'(i) < count_r);

    bber_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_idx  (bber_pkg::IDX_W'(i)),
      .active  (active[i]),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // The finished request waits here until the output register is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (tok[bber_pkg::MAX_EXTENTS].valid) begin
      res_valid_r <= 1'b1;
    end else if (out_load) begin
      res_valid_r <= 1'b0;
    end
    if (tok[bber_pkg::MAX_EXTENTS].valid) begin
      res_hit_r  <= tok[bber_pkg::MAX_EXTENTS].hit;
      res_phys_r <= tok[bber_pkg::MAX_EXTENTS].phys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_found_r <= res_hit_r;
      out_phys_r  <= res_phys_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_physical_block = out_phys_r;
  assign out_found          = out_found_r;
  assign out_table_overflow = out_ovf_r;

endmodule
